// ===== hw/rtl/mdl_pkg.sv =====
// Package for the magnetic dipole lead-field core: payload structs, register
// indexes, pipeline stage records and arithmetic constants.
// No dependencies; every other file in hw/rtl imports it.
package mdl_pkg;

  localparam int unsigned POS_W        = 24;
  localparam int unsigned ORI_W        = 16;
  localparam int unsigned FIELD_W      = 40;
  localparam int unsigned LANES        = 3;
  // Quotient bits of |N| * 2^40 / r2, which stays below 2^58.
  localparam int unsigned DIV_T_STEPS  = 58;
  // Result bits of the integer square root of r2 * 2^14.
  localparam int unsigned SQRT_STEPS   = 32;
  // Quotient bits kept by the final division; larger values saturate.
  localparam int unsigned DIV_Q_STEPS  = 40;
  // round(2^58 * 1e-7 / (4 * pi))
  localparam logic [31:0] K_SCALED     = 32'd2293664456;
  localparam logic [FIELD_W-1:0] POS_LIM = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] NEG_LIM = {1'b1, {(FIELD_W-1){1'b0}}};

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [ORI_W-1:0] ori_t;

  typedef enum logic [1:0] {
    REG_DIPOLE_X = 2'd0,
    REG_DIPOLE_Y = 2'd1,
    REG_DIPOLE_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    pos_t sensor_x;
    pos_t sensor_y;
    pos_t sensor_z;
    ori_t orient_x;
    ori_t orient_y;
    ori_t orient_z;
    logic last_channel;
  } mdl_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic                      too_close;
    logic                      saturated;
    logic                      last_out;
  } mdl_out_t;

  // One lane of the first divider: partial remainder and the word that
  // shifts dividend bits out and quotient bits in.
  typedef struct packed {
    logic [49:0] rem;
    logic [57:0] x;
  } div_lane_t;

  // Record that runs through the first divider and the square root.
  typedef struct packed {
    logic                  last;
    logic                  close;
    logic [LANES-1:0]      neg;
    logic [49:0]           r2;
    div_lane_t [LANES-1:0] lane;
    logic [63:0]           sv;
    logic [63:0]           sres;
  } tstage_t;

endpackage

// ===== hw/rtl/mdl_front.sv =====
// Front end of the lead-field pipeline: offset, squares, dot product and the
// numerators N_j, seven register stages. Hands a tstage_t to the dividers.
// Depends on mdl_pkg.
module mdl_front import mdl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  mdl_in_t          data_i,
  input  pos_t [LANES-1:0] dipole_i,
  output logic             valid_o,
  output tstage_t          stage_o
);

  localparam int unsigned STAGES = 7;

  typedef struct packed {
    logic                   last;
    logic [LANES-1:0][24:0] d;
    logic [LANES-1:0][15:0] o;
  } f1_t;

  typedef struct packed {
    logic                   last;
    logic [LANES-1:0][24:0] d;
    logic [LANES-1:0][15:0] o;
    logic [LANES-1:0][49:0] sq;
    logic [LANES-1:0][40:0] dp;
  } f2_t;

  typedef struct packed {
    logic                   last;
    logic [LANES-1:0][24:0] d;
    logic [LANES-1:0][15:0] o;
    logic [49:0]            r2;
    logic [42:0]            dot;
  } f3_t;

  typedef struct packed {
    logic                   last;
    logic [49:0]            r2;
    logic [LANES-1:0][46:0] pdl;
    logic [LANES-1:0][46:0] pdh;
    logic [LANES-1:0][41:0] prl;
    logic [LANES-1:0][41:0] prh;
  } f4_t;

  typedef struct packed {
    logic                   last;
    logic [49:0]            r2;
    logic [LANES-1:0][71:0] dd;
    logic [LANES-1:0][71:0] oo;
  } f5_t;

  typedef struct packed {
    logic                   last;
    logic [49:0]            r2;
    logic [LANES-1:0][71:0] n;
  } f6_t;

  f1_t f1_d, f1_q;
  f2_t f2_d, f2_q;
  f3_t f3_d, f3_q;
  f4_t f4_d, f4_q;
  f5_t f5_d, f5_q;
  f6_t f6_d, f6_q;
  tstage_t f7_d, f7_q;
  logic [STAGES-1:0] v_q;

  pos_t [LANES-1:0] sensor;
  ori_t [LANES-1:0] orient;

  assign sensor = {data_i.sensor_z, data_i.sensor_y, data_i.sensor_x};
  assign orient = {data_i.orient_z, data_i.orient_y, data_i.orient_x};

  always_comb begin
    f1_d.last = data_i.last_channel;
    for (int j = 0; j < LANES; j++) begin
      f1_d.d[j] = 25'($signed(sensor[j])) - 25'($signed(dipole_i[j]));
      f1_d.o[j] = orient[j];
    end
  end

  always_comb begin
    logic signed [49:0] sq;
    logic signed [40:0] dp;
    f2_d.last = f1_q.last;
    f2_d.d    = f1_q.d;
    f2_d.o    = f1_q.o;
    for (int j = 0; j < LANES; j++) begin
      sq = $signed(f1_q.d[j]) * $signed(f1_q.d[j]);
      dp = $signed(f1_q.d[j]) * $signed(f1_q.o[j]);
      f2_d.sq[j] = sq;
      f2_d.dp[j] = dp;
    end
  end

  always_comb begin
    f3_d.last = f2_q.last;
    f3_d.d    = f2_q.d;
    f3_d.o    = f2_q.o;
    f3_d.r2   = f2_q.sq[0] + f2_q.sq[1] + f2_q.sq[2];
    f3_d.dot  = 43'($signed(f2_q.dp[0])) + 43'($signed(f2_q.dp[1]))
              + 43'($signed(f2_q.dp[2]));
  end

  // The wide products are cut into halves so that no multiplier exceeds
  // about 25 by 22 bits.
  always_comb begin
    logic signed [21:0] dot_lo;
    logic signed [21:0] dot_hi;
    logic signed [25:0] r2_lo;
    logic signed [25:0] r2_hi;
    logic signed [46:0] pd_l;
    logic signed [46:0] pd_h;
    logic signed [41:0] pr_l;
    logic signed [41:0] pr_h;
    dot_lo = $signed({1'b0, f3_q.dot[20:0]});
    dot_hi = $signed(f3_q.dot[42:21]);
    r2_lo  = $signed({1'b0, f3_q.r2[24:0]});
    r2_hi  = $signed({1'b0, f3_q.r2[49:25]});
    f4_d.last = f3_q.last;
    f4_d.r2   = f3_q.r2;
    for (int j = 0; j < LANES; j++) begin
      pd_l = $signed(f3_q.d[j]) * dot_lo;
      pd_h = $signed(f3_q.d[j]) * dot_hi;
      pr_l = $signed(f3_q.o[j]) * r2_lo;
      pr_h = $signed(f3_q.o[j]) * r2_hi;
      f4_d.pdl[j] = pd_l;
      f4_d.pdh[j] = pd_h;
      f4_d.prl[j] = pr_l;
      f4_d.prh[j] = pr_h;
    end
  end

  always_comb begin
    logic signed [71:0] dd;
    logic signed [71:0] oo;
    f5_d.last = f4_q.last;
    f5_d.r2   = f4_q.r2;
    for (int j = 0; j < LANES; j++) begin
      dd = (72'($signed(f4_q.pdh[j])) <<< 21) + 72'($signed(f4_q.pdl[j]));
      oo = (72'($signed(f4_q.prh[j])) <<< 25) + 72'($signed(f4_q.prl[j]));
      f5_d.dd[j] = dd;
      f5_d.oo[j] = oo;
    end
  end

  always_comb begin
    f6_d.last = f5_q.last;
    f6_d.r2   = f5_q.r2;
    for (int j = 0; j < LANES; j++) begin
      f6_d.n[j] = f5_q.dd[j] + {f5_q.dd[j][70:0], 1'b0} - f5_q.oo[j];
    end
  end

  // |N| stays below 2^18 * r2, so its top 50 bits are already smaller than
  // the divisor and the first divider needs only 58 quotient steps.
  always_comb begin
    logic [71:0] mag;
    f7_d.last  = f6_q.last;
    f7_d.close = (f6_q.r2 == 50'd0);
    f7_d.r2    = f6_q.r2;
    f7_d.sv    = {f6_q.r2, 14'd0};
    f7_d.sres  = 64'd0;
    for (int j = 0; j < LANES; j++) begin
      f7_d.neg[j]      = f6_q.n[j][71];
      mag              = f6_q.n[j][71] ? (72'd0 - f6_q.n[j]) : f6_q.n[j];
      f7_d.lane[j].rem = mag[67:18];
      f7_d.lane[j].x   = {mag[17:0], 40'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
      f3_q <= f3_d;
      f4_q <= f4_d;
      f5_q <= f5_d;
      f6_q <= f6_d;
      f7_q <= f7_d;
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign stage_o = f7_q;

endmodule

// ===== hw/rtl/magnetic_dipole_leadfield_core.sv =====
// Magnetic dipole lead-field core: takes one sensor channel per cycle, unless
// the pipeline is held by a full skid register, and returns the three lead-field
// values. An accepted channel passes 7 front stages (the first loaded at the
// accepting edge), 58 stages of the |N|/r2 divider (the square root runs in its
// first 32), 3 multiply and compare stages, 40 stages of the final divider, a
// clip stage and the output register. Reset clears all valid bits and the dipole registers.
module magnetic_dipole_leadfield_core import mdl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mdl_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output mdl_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  pos_t       cfg_data_i
);

  typedef struct packed {
    logic                   last;
    logic                   close;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0][60:0] kp_lo;
    logic [LANES-1:0][60:0] kp_hi;
    logic [56:0]            rp_lo;
    logic [56:0]            rp_hi;
  } m1_t;

  typedef struct packed {
    logic                   last;
    logic                   close;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0][89:0] xn;
    logic [86:0]            m;
  } m2_t;

  typedef struct packed {
    logic [86:0] rem;
    logic [39:0] x;
  } q_lane_t;

  typedef struct packed {
    logic                last;
    logic                close;
    logic [LANES-1:0]    neg;
    logic [LANES-1:0]    ovf;
    logic [86:0]         m;
    q_lane_t [LANES-1:0] lane;
  } e_t;

  pos_t [LANES-1:0] dipole_q;

  logic    en;
  logic    fr_v;
  tstage_t fr_stage;

  tstage_t ts_q [DIV_T_STEPS];
  logic [DIV_T_STEPS-1:0] tv_q;

  m1_t  m1_d, m1_q;
  m2_t  m2_d, m2_q;
  e_t   c_d;
  e_t   es_q [DIV_Q_STEPS+1];
  logic [DIV_Q_STEPS+2:0] ev_q;

  mdl_out_t z_d, z_q;
  logic     zv_q;

  mdl_out_t out_q, skid_q;
  logic     out_v_q, skid_v_q;
  logic     out_fire, new_res;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dipole_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DIPOLE_X: dipole_q[0] <= cfg_data_i;
        REG_DIPOLE_Y: dipole_q[1] <= cfg_data_i;
        REG_DIPOLE_Z: dipole_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only while the skid register
  // is occupied.
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  mdl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i && in_ready_o),
    .data_i   (in_data_i),
    .dipole_i (dipole_q),
    .valid_o  (fr_v),
    .stage_o  (fr_stage)
  );

  // First divider, one quotient bit per stage, with the square root of
  // r2 * 2^14 sharing the first SQRT_STEPS stages.
  for (genvar k = 0; k < DIV_T_STEPS; k++) begin : g_tdiv
    localparam int unsigned SB = (k < SQRT_STEPS) ? (62 - 2 * k) : 0;
    localparam logic [63:0] SBIT = 64'd1 << SB;
    tstage_t cur, nxt;

    if (k == 0) begin : g_first
      assign cur = fr_stage;
    end else begin : g_next
      assign cur = ts_q[k-1];
    end

    always_comb begin
      logic [50:0] t;
      logic        ge;
      logic [63:0] trial;
      nxt = cur;
      for (int j = 0; j < LANES; j++) begin
        t  = {cur.lane[j].rem, cur.lane[j].x[57]};
        ge = (t >= {1'b0, cur.r2});
        nxt.lane[j].rem = ge ? 50'(t - {1'b0, cur.r2}) : t[49:0];
        nxt.lane[j].x   = {cur.lane[j].x[56:0], ge};
      end
      trial = cur.sres + SBIT;
      if (k < SQRT_STEPS) begin
        if (cur.sv >= trial) begin
          nxt.sv   = cur.sv - trial;
          nxt.sres = (cur.sres >> 1) + SBIT;
        end else begin
          nxt.sres = cur.sres >> 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ts_q[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (en) begin
      tv_q <= {tv_q[DIV_T_STEPS-2:0], fr_v};
    end
  end

  // Partial products of K * T and r2 * R.
  always_comb begin
    logic [31:0] root;
    root       = ts_q[DIV_T_STEPS-1].sres[31:0];
    m1_d.last  = ts_q[DIV_T_STEPS-1].last;
    m1_d.close = ts_q[DIV_T_STEPS-1].close;
    m1_d.neg   = ts_q[DIV_T_STEPS-1].neg;
    for (int j = 0; j < LANES; j++) begin
      m1_d.kp_lo[j] = K_SCALED * ts_q[DIV_T_STEPS-1].lane[j].x[28:0];
      m1_d.kp_hi[j] = K_SCALED * ts_q[DIV_T_STEPS-1].lane[j].x[57:29];
    end
    m1_d.rp_lo = ts_q[DIV_T_STEPS-1].r2[24:0] * root;
    m1_d.rp_hi = ts_q[DIV_T_STEPS-1].r2[49:25] * root;
  end

  always_comb begin
    logic [81:0] r2r;
    m2_d.last  = m1_q.last;
    m2_d.close = m1_q.close;
    m2_d.neg   = m1_q.neg;
    for (int j = 0; j < LANES; j++) begin
      m2_d.xn[j] = {29'd0, m1_q.kp_lo[j]} + {m1_q.kp_hi[j], 29'd0};
    end
    r2r    = {m1_q.rp_hi, 25'd0} + 82'(m1_q.rp_lo);
    m2_d.m = {r2r, 5'd0};
  end

  // A quotient of 2^40 or more is flagged here; the divider below then only
  // has to produce the low 40 bits.
  always_comb begin
    c_d.last  = m2_q.last;
    c_d.close = m2_q.close;
    c_d.neg   = m2_q.neg;
    c_d.m     = m2_q.m;
    for (int j = 0; j < LANES; j++) begin
      c_d.ovf[j]      = ({37'd0, m2_q.xn[j]} >= {m2_q.m, 40'd0});
      c_d.lane[j].rem = {37'd0, m2_q.xn[j][89:40]};
      c_d.lane[j].x   = m2_q.xn[j][39:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      es_q[0] <= c_d;
    end
  end

  for (genvar k = 0; k < DIV_Q_STEPS; k++) begin : g_qdiv
    e_t nxt;

    always_comb begin
      logic [87:0] t;
      logic        ge;
      nxt = es_q[k];
      for (int j = 0; j < LANES; j++) begin
        t  = {es_q[k].lane[j].rem, es_q[k].lane[j].x[39]};
        ge = (t >= {1'b0, es_q[k].m});
        nxt.lane[j].rem = ge ? 87'(t - {1'b0, es_q[k].m}) : t[86:0];
        nxt.lane[j].x   = {es_q[k].lane[j].x[38:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        es_q[k+1] <= nxt;
      end
    end
  end

  // The two low valid bits travel with m1_q and m2_q; the rest with es_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else if (en) begin
      ev_q <= {ev_q[DIV_Q_STEPS+1:0], tv_q[DIV_T_STEPS-1]};
    end
  end

  // Clip, sign and the coincident-sensor case.
  always_comb begin
    logic [FIELD_W-1:0] lim;
    logic [FIELD_W-1:0] mag;
    logic [LANES-1:0]   sat;
    logic [LANES-1:0][FIELD_W-1:0] fld;
    for (int j = 0; j < LANES; j++) begin
      lim    = es_q[DIV_Q_STEPS].neg[j] ? NEG_LIM : POS_LIM;
      sat[j] = es_q[DIV_Q_STEPS].ovf[j] || (es_q[DIV_Q_STEPS].lane[j].x > lim);
      mag    = sat[j] ? lim : es_q[DIV_Q_STEPS].lane[j].x;
      fld[j] = es_q[DIV_Q_STEPS].neg[j] ? (FIELD_W'(0) - mag) : mag;
    end
    if (es_q[DIV_Q_STEPS].close) begin
      z_d.field_x   = '0;
      z_d.field_y   = '0;
      z_d.field_z   = '0;
      z_d.too_close = 1'b1;
      z_d.saturated = 1'b0;
    end else begin
      z_d.field_x   = fld[0];
      z_d.field_y   = fld[1];
      z_d.field_z   = fld[2];
      z_d.too_close = 1'b0;
      z_d.saturated = |sat;
    end
    z_d.last_out = es_q[DIV_Q_STEPS].last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zv_q <= 1'b0;
    end else if (en) begin
      zv_q <= ev_q[DIV_Q_STEPS+2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q <= z_d;
    end
  end

  // Output register with a skid register behind it, so a stalled result does
  // not stop the pipeline until a second one arrives.
  assign out_fire = out_v_q && out_ready_i;
  assign new_res  = en && zv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (new_res) begin
      if (out_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (new_res) begin
      if (out_v_q && !out_ready_i) begin
        skid_q <= z_q;
      end else begin
        out_q <= z_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid register filled while the output was free");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.too_close) |->
      (out_q.field_x == '0 && out_q.field_y == '0 && out_q.field_z == '0 &&
       !out_q.saturated))
    else $error("coincident sensor produced nonzero fields or a clip flag");
`endif

endmodule
